>>> sv/nbrt_pkg.sv
// Package for the NAND block remap table: beat types, register indexes,
// controller states and geometry constants. No dependencies.
`default_nettype none

package nbrt_pkg;

    localparam int MAP_ENTRIES_DEF = 4096;

    localparam logic [7:0] SPARE_MARK    = 8'hFF;
    localparam int         SECTOR_LOG2   = 9;
    localparam int         PHYS_W        = 26;
    localparam int         SECTOR_W      = 22;
    localparam int         BLOCK_W       = 16;
    localparam int         COUNT_W       = 17;
    localparam int         LOGICAL_W     = 12;
    localparam int         SHIFT_W       = 4;
    localparam int         CFG_IDX_W     = 2;

    localparam logic [3:0] PAGE_LOG2_MIN  = 4'd10;
    localparam logic [3:0] PAGE_LOG2_MAX  = 4'd13;
    localparam logic [3:0] BLOCK_LOG2_MIN = 4'd3;
    localparam logic [3:0] BLOCK_LOG2_MAX = 4'd9;

    localparam logic [3:0]         PAGE_LOG2_RST   = 4'd11;
    localparam logic [3:0]         BLOCK_LOG2_RST  = 4'd6;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 17'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAGE_BYTES_LOG2  = 2'd0,
        REG_BLOCK_PAGES_LOG2 = 2'd1,
        REG_BLOCK_COUNT      = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_RECORD    = 1'b0,
        OP_TRANSLATE = 1'b1
    } op_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic                op;
        logic [BLOCK_W-1:0]  block_index;
        logic [7:0]          spare_first;
        logic [7:0]          spare_second;
        logic [7:0]          spare_third;
        logic [SECTOR_W-1:0] sector;
        logic                use_map;
    } in_beat_t;

    typedef struct packed {
        logic [PHYS_W-1:0] phys_sector;
        logic              out_of_range;
    } out_beat_t;

endpackage

`default_nettype wire

>>> sv/nand_block_remap_table_unit.sv
// NAND logical-to-physical block remap table: map memory, record/translate
// pipeline and geometry registers. Depends on nbrt_pkg.
//
// Usage: the s_ channel carries one beat per operation. A record beat
// (op 0) with a valid spare marker and in-range indexes stores its physical
// block in the map and produces no result. A translate beat (op 1) produces
// exactly one m_ beat holding the physical sector and an out-of-range flag.
// The map lives in one single-port-write, one-read synchronous memory.
// A translate beat reads it in the cycle it is accepted; the read data is
// registered in the memory read stage, then moves into the output register,
// which drives m_valid. One beat of either kind is accepted per cycle while
// s_ready is high; read stage and output register form a two-entry pipeline.
// When the receiver stalls, the output register holds its beat, the read
// stage fills, and then s_ready drops until m_ready returns.
// After reset the map is swept to zero, one entry per cycle; s_ready stays
// low during the sweep. Configuration writes are taken at any time, including
// during the sweep.
`default_nettype none

module nand_block_remap_table_unit
    import nbrt_pkg::*;
#(
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_beat_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_beat_t                 m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COUNT_W-1:0]   cfg_wr_data
);

    localparam int IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam logic [IDX_W-1:0]     LAST_IDX    = IDX_W'(MAP_ENTRIES - 1);
    localparam logic [LOGICAL_W:0]   ENTRIES_REC = (LOGICAL_W + 1)'(MAP_ENTRIES);
    localparam logic [SECTOR_W-1:0]  ENTRIES_SEC = SECTOR_W'(MAP_ENTRIES);
    localparam int                   WIDE_W      = BLOCK_W + 13;

    logic [BLOCK_W-1:0] mem [MAP_ENTRIES];

    ctrl_state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;

    logic [3:0]         page_log2_reg;
    logic [3:0]         block_log2_reg;
    logic [COUNT_W-1:0] block_count_reg;

    logic                pend_valid_reg;
    logic                pend_use_map_reg;
    logic                pend_oor_reg;
    logic [SECTOR_W-1:0] pend_sector_reg;
    logic [SHIFT_W-1:0]  pend_shift_reg;
    logic [BLOCK_W-1:0]  rd_data_reg;

    logic      out_valid_reg;
    out_beat_t out_data_reg, out_data_next;

    logic                 accept;
    logic                 out_free;
    logic                 do_read;
    logic                 rec_ok;
    logic [LOGICAL_W-1:0] rec_logical;
    logic [3:0]           page_log2_sat;
    logic [3:0]           block_log2_sat;
    logic [4:0]           shift_sum;
    logic [SHIFT_W-1:0]   shift_amt;
    logic [SECTOR_W-1:0]  tr_logical;
    logic                 tr_oor;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [BLOCK_W-1:0]   mem_wdata;
    logic [SECTOR_W-1:0]  offset_mask;
    logic [WIDE_W-1:0]    phys_wide;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_RUN) && (!pend_valid_reg || out_free);
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        page_log2_sat = page_log2_reg;
        if (page_log2_reg < PAGE_LOG2_MIN) begin
            page_log2_sat = PAGE_LOG2_MIN;
        end else if (page_log2_reg > PAGE_LOG2_MAX) begin
            page_log2_sat = PAGE_LOG2_MAX;
        end
        block_log2_sat = block_log2_reg;
        if (block_log2_reg < BLOCK_LOG2_MIN) begin
            block_log2_sat = BLOCK_LOG2_MIN;
        end else if (block_log2_reg > BLOCK_LOG2_MAX) begin
            block_log2_sat = BLOCK_LOG2_MAX;
        end
        shift_sum = {1'b0, page_log2_sat} + {1'b0, block_log2_sat} - 5'(SECTOR_LOG2);
        shift_amt = shift_sum[SHIFT_W-1:0];
    end

    always_comb begin
        rec_logical = {s_data.spare_second[3:0], s_data.spare_third};
        rec_ok = (s_data.spare_first == SPARE_MARK)
              && (s_data.spare_second != SPARE_MARK)
              && ({1'b0, s_data.block_index} < block_count_reg)
              && ({1'b0, rec_logical} < ENTRIES_REC);
        tr_logical = s_data.sector >> shift_amt;
        tr_oor     = tr_logical >= ENTRIES_SEC;
        do_read    = accept && (s_data.op == OP_TRANSLATE);
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = rec_logical[IDX_W-1:0];
        mem_wdata     = s_data.block_index;
        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_IDX) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                mem_we = accept && (s_data.op == OP_RECORD) && rec_ok;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (do_read) begin
            rd_data_reg <= mem[tr_logical[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_log2_reg   <= PAGE_LOG2_RST;
            block_log2_reg  <= BLOCK_LOG2_RST;
            block_count_reg <= BLOCK_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PAGE_BYTES_LOG2:  page_log2_reg   <= cfg_wr_data[3:0];
                REG_BLOCK_PAGES_LOG2: block_log2_reg  <= cfg_wr_data[3:0];
                REG_BLOCK_COUNT:      block_count_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (s_ready) begin
            pend_valid_reg <= do_read;
        end else if (out_free) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_read) begin
            pend_use_map_reg <= s_data.use_map;
            pend_oor_reg     <= tr_oor;
            pend_sector_reg  <= s_data.sector;
            pend_shift_reg   <= shift_amt;
        end
    end

    always_comb begin
        offset_mask = (SECTOR_W'(1) << pend_shift_reg) - SECTOR_W'(1);
        phys_wide   = (WIDE_W'(rd_data_reg) << pend_shift_reg)
                    | WIDE_W'(pend_sector_reg & offset_mask);
        out_data_next = '0;
        if (!pend_use_map_reg) begin
            out_data_next.phys_sector = PHYS_W'(pend_sector_reg);
        end else if (pend_oor_reg) begin
            out_data_next.out_of_range = 1'b1;
        end else begin
            out_data_next.phys_sector = phys_wide[PHYS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= pend_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && pend_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
